[rtl/pcs_pkg.sv]
// Shared types and constants of the prime counting sieve.
// Has no dependencies; pcs_div and prime_counting_sieve import it.
package pcs_pkg;

   localparam int VALUE_W = 25;
   localparam int DATA_W  = 32;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ROOT,
      ST_INIT_DIV,
      ST_INIT_WAIT,
      ST_P_RD_PREV,
      ST_P_RD_CUR,
      ST_P_CHECK,
      ST_SQ,
      ST_END_DIV,
      ST_END_WAIT,
      ST_L_OTHER,
      ST_L_DIV,
      ST_L_OTHER_CAP,
      ST_L_CUR,
      ST_S_CHK,
      ST_S_DIV,
      ST_S_WAIT,
      ST_S_RDI,
      ST_S_WR,
      ST_Q,
      ST_Q_DIV,
      ST_Q_RD,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic done;
   } div_ctl_type;

endpackage

[rtl/pcs_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Has no dependencies.
module pcs_ram #(
   parameter int WIDTH = 25,
   parameter int DEPTH = 4097
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[rtl/pcs_div.sv]
// Restoring divider, one quotient bit per cycle.
// Uses pcs_pkg for the control struct.
module pcs_div import pcs_pkg::*; #(
   parameter int W = 25
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [W-1:0]  dividend,
   input  logic [W-1:0]  divisor,
   output div_ctl_type   status,
   output logic [W-1:0]  quotient
);

   localparam int CNT_W = $clog2(W + 1);

   logic [W-1:0]     rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in, done_ff, done_in;
   logic [W:0]       shifted, trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[W-1]};
      trial   = shifted - {1'b0, dvs_ff};
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
         cnt_in = CNT_W'(W);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign status.start = start;
   assign status.done  = done_ff;
   assign quotient     = quo_ff;

endmodule

[rtl/prime_counting_sieve.sv]
// Top level of the prime counting sieve: sequencer, root search and table build.
// Uses pcs_pkg, pcs_div and two pcs_ram instances.
//
// Channel  Dir  Signals                               Contents
// req      in   req_tvalid/tready, req_tdata[31:0]    query_value [24:0]
// rsp      out  rsp_tvalid/tready, rsp_tdata[31:0]    prime_count [24:0]
//               rsp_tuser[0]                          query_ok
// csr      in   csr_valid/ready, csr_data[24:0]       upper_limit
//
// Once the tables are built, a query above the root is classified, then the shared
// divider forms n/x, and one table read and the output state follow. A query up to
// the root skips the divider, and an out-of-range query also skips the table read.
// The first query after reset or a register write first runs a root search and a
// table build whose length grows with n (a divider run for most sieve updates).
// The input is not ready while an item is in work or its result waits.
// Reset is synchronous; the tables hold nothing until the first build.
module prime_counting_sieve import pcs_pkg::*; #(
   parameter int MAX_ROOT = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [DATA_W-1:0]  req_tdata,   // query_value
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [DATA_W-1:0]  rsp_tdata,   // prime_count
   output logic [0:0]         rsp_tuser,   // query_ok
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [VALUE_W-1:0] csr_data     // upper_limit
);

   localparam int NW    = VALUE_W;
   localparam int DEPTH = MAX_ROOT + 1;
   localparam int RW    = $clog2(DEPTH);
   localparam int CW    = RW + 1;
   localparam int BW    = $clog2(RW + 1);
   localparam longint unsigned CAP = longint'(MAX_ROOT) * longint'(MAX_ROOT);

   state_type state_ff, state_in;
   logic [NW-1:0] ul_ff, ul_in, x_ff, x_in, d_ff, d_in, sq_ff, sq_in;
   logic [NW-1:0] end_ff, end_in, below_ff, below_in, other_ff, other_in;
   logic [NW-1:0] count_ff, count_in;
   logic          ready_ff, ready_in, ok_ff, ok_in;
   logic [RW-1:0] root_ff, root_in;
   logic [CW-1:0] p_ff, p_in, i_ff, i_in;
   logic [BW-1:0] bit_ff, bit_in;

   logic [NW-1:0]     n_eff, v_ext;
   logic [RW-1:0]     cand;
   logic [2*RW-1:0]   cand_sq;
   logic [2*CW-1:0]   p_sq;
   logic [CW-1:0]     pm1;

   logic              div_start;
   logic [NW-1:0]     div_a, div_b, div_q;
   div_ctl_type       div_st;

   logic              s_we, l_we;
   logic [RW-1:0]     s_wa, l_wa, s_ra, l_ra;
   logic [NW-1:0]     s_wd, l_wd, s_rd, l_rd;

   always_comb begin
      if (ul_ff == '0) begin
         n_eff = NW'(1);
      end else if (64'(ul_ff) > CAP) begin
         n_eff = NW'(CAP);
      end else begin
         n_eff = ul_ff;
      end
   end

   assign v_ext   = NW'(root_ff);
   assign cand    = root_ff | (RW'(1) << bit_ff);
   assign cand_sq = {{RW{1'b0}}, cand} * {{RW{1'b0}}, cand};
   assign p_sq    = {{CW{1'b0}}, p_ff} * {{CW{1'b0}}, p_ff};
   assign pm1     = p_ff - CW'(1);

   pcs_div #(.W(NW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .status   (div_st),
      .quotient (div_q)
   );

   pcs_ram #(.WIDTH(NW), .DEPTH(DEPTH)) u_small (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_wa),
      .wr_data (s_wd),
      .rd_addr (s_ra),
      .rd_data (s_rd)
   );

   pcs_ram #(.WIDTH(NW), .DEPTH(DEPTH)) u_large (
      .clock   (clock),
      .wr_en   (l_we),
      .wr_addr (l_wa),
      .wr_data (l_wd),
      .rd_addr (l_ra),
      .rd_data (l_rd)
   );

   always_comb begin
      state_in  = state_ff;
      ul_in     = ul_ff;
      x_in      = x_ff;
      d_in      = d_ff;
      sq_in     = sq_ff;
      end_in    = end_ff;
      below_in  = below_ff;
      other_in  = other_ff;
      count_in  = count_ff;
      ready_in  = ready_ff;
      ok_in     = ok_ff;
      root_in   = root_ff;
      p_in      = p_ff;
      i_in      = i_ff;
      bit_in    = bit_ff;
      div_start = 1'b0;
      div_a     = n_eff;
      div_b     = NW'(p_ff);
      s_we      = 1'b0;
      l_we      = 1'b0;
      s_wa      = p_ff[RW-1:0];
      l_wa      = p_ff[RW-1:0];
      s_wd      = NW'(pm1);
      l_wd      = div_q - NW'(1);
      s_ra      = i_ff[RW-1:0];
      l_ra      = i_ff[RW-1:0];
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               x_in = req_tdata[NW-1:0];
               if (ready_ff) begin
                  state_in = ST_Q;
               end else begin
                  root_in  = '0;
                  bit_in   = BW'(RW - 1);
                  state_in = ST_ROOT;
               end
            end
         end
         ST_ROOT: begin
            if (64'(cand_sq) <= 64'(n_eff)) begin
               root_in = cand;
            end
            if (bit_ff == '0) begin
               p_in     = CW'(1);
               state_in = ST_INIT_DIV;
            end else begin
               bit_in = bit_ff - BW'(1);
            end
         end
         ST_INIT_DIV: begin
            div_start = 1'b1;
            state_in  = ST_INIT_WAIT;
         end
         ST_INIT_WAIT: begin
            if (div_st.done) begin
               s_we = 1'b1;
               l_we = 1'b1;
               if (NW'(p_ff) == v_ext) begin
                  p_in     = CW'(2);
                  state_in = ST_P_RD_PREV;
               end else begin
                  p_in     = p_ff + CW'(1);
                  state_in = ST_INIT_DIV;
               end
            end
         end
         ST_P_RD_PREV: begin
            s_ra = pm1[RW-1:0];
            if (NW'(p_ff) > v_ext) begin
               ready_in = 1'b1;
               state_in = ST_Q;
            end else begin
               state_in = ST_P_RD_CUR;
            end
         end
         ST_P_RD_CUR: begin
            below_in = s_rd;
            s_ra     = p_ff[RW-1:0];
            state_in = ST_P_CHECK;
         end
         ST_P_CHECK: begin
            if (s_rd == below_ff) begin
               p_in     = p_ff + CW'(1);
               state_in = ST_P_RD_PREV;
            end else begin
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            sq_in    = NW'(p_sq);
            state_in = ST_END_DIV;
         end
         ST_END_DIV: begin
            div_start = 1'b1;
            div_b     = sq_ff;
            state_in  = ST_END_WAIT;
         end
         ST_END_WAIT: begin
            if (div_st.done) begin
               end_in   = (div_q > v_ext) ? v_ext : div_q;
               i_in     = CW'(1);
               d_in     = NW'(p_ff);
               state_in = ST_L_OTHER;
            end
         end
         ST_L_OTHER: begin
            l_ra = d_ff[RW-1:0];
            if (d_ff <= v_ext) begin
               state_in = ST_L_OTHER_CAP;
            end else begin
               div_start = 1'b1;
               div_b     = d_ff;
               state_in  = ST_L_DIV;
            end
         end
         ST_L_DIV: begin
            s_ra = div_q[RW-1:0];
            if (div_st.done) begin
               state_in = ST_L_OTHER_CAP;
            end
         end
         ST_L_OTHER_CAP: begin
            other_in = (d_ff <= v_ext) ? l_rd : s_rd;
            l_ra     = i_ff[RW-1:0];
            state_in = ST_L_CUR;
         end
         ST_L_CUR: begin
            l_we = 1'b1;
            l_wa = i_ff[RW-1:0];
            l_wd = l_rd - (other_ff - below_ff);
            if (NW'(i_ff) == end_ff) begin
               i_in     = CW'(root_ff);
               state_in = ST_S_CHK;
            end else begin
               i_in     = i_ff + CW'(1);
               d_in     = d_ff + NW'(p_ff);
               state_in = ST_L_OTHER;
            end
         end
         ST_S_CHK: begin
            if (sq_ff > v_ext) begin
               p_in     = p_ff + CW'(1);
               state_in = ST_P_RD_PREV;
            end else begin
               state_in = ST_S_DIV;
            end
         end
         ST_S_DIV: begin
            div_start = 1'b1;
            div_a     = NW'(i_ff);
            state_in  = ST_S_WAIT;
         end
         ST_S_WAIT: begin
            s_ra = div_q[RW-1:0];
            if (div_st.done) begin
               state_in = ST_S_RDI;
            end
         end
         ST_S_RDI: begin
            other_in = s_rd;
            s_ra     = i_ff[RW-1:0];
            state_in = ST_S_WR;
         end
         ST_S_WR: begin
            s_we = 1'b1;
            s_wa = i_ff[RW-1:0];
            s_wd = s_rd - (other_ff - below_ff);
            if (NW'(i_ff) == sq_ff) begin
               p_in     = p_ff + CW'(1);
               state_in = ST_P_RD_PREV;
            end else begin
               i_in     = i_ff - CW'(1);
               state_in = ST_S_DIV;
            end
         end
         ST_Q: begin
            s_ra = x_ff[RW-1:0];
            if (x_ff == '0 || x_ff > n_eff) begin
               count_in = '0;
               ok_in    = 1'b0;
               state_in = ST_OUT;
            end else if (x_ff <= v_ext) begin
               state_in = ST_Q_RD;
            end else begin
               div_start = 1'b1;
               div_b     = x_ff;
               state_in  = ST_Q_DIV;
            end
         end
         ST_Q_DIV: begin
            l_ra = div_q[RW-1:0];
            if (div_st.done) begin
               state_in = ST_Q_RD;
            end
         end
         ST_Q_RD: begin
            count_in = (x_ff <= v_ext) ? s_rd : l_rd;
            ok_in    = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_valid) begin
         ul_in    = csr_data;
         ready_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ul_ff    <= NW'(1);
         ready_ff <= 1'b0;
         root_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ul_ff    <= ul_in;
         ready_ff <= ready_in;
         root_ff  <= root_in;
      end
      x_ff     <= x_in;
      d_ff     <= d_in;
      sq_ff    <= sq_in;
      end_ff   <= end_in;
      below_ff <= below_in;
      other_ff <= other_in;
      count_ff <= count_in;
      ok_ff    <= ok_in;
      p_ff     <= p_in;
      i_ff     <= i_in;
      bit_ff   <= bit_in;
   end

   assign csr_ready = 1'b1;
   assign rsp_tdata = DATA_W'(count_ff);
   assign rsp_tuser = ok_ff;

endmodule
